/* rtl/core/srs_pkg.sv */
`default_nettype none

package srs_pkg;

  // Request codes carried in the input item.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_CW90  = 3'd1;
  localparam logic [2:0] REQ_CW180 = 3'd2;
  localparam logic [2:0] REQ_CCW90 = 3'd3;
  localparam logic [2:0] REQ_HOME  = 3'd4;

  // Move mode uses the request codes; zero means idle.
  localparam logic [2:0] MODE_IDLE = 3'd0;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BASE_DELAY = 3'd0;
  localparam logic [2:0] CFG_HOME_DELAY = 3'd1;
  localparam logic [2:0] CFG_PATTERN_0  = 3'd2;
  localparam logic [2:0] CFG_PATTERN_1  = 3'd3;
  localparam logic [2:0] CFG_PATTERN_2  = 3'd4;
  localparam logic [2:0] CFG_PATTERN_3  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [5:0] BASE_DELAY_RST = 6'd6;
  localparam logic [7:0] HOME_DELAY_RST = 8'd20;
  localparam logic [7:0] PATTERN_0_RST  = 8'b0011_0110;
  localparam logic [7:0] PATTERN_1_RST  = 8'b0010_1110;
  localparam logic [7:0] PATTERN_2_RST  = 8'b0010_1101;
  localparam logic [7:0] PATTERN_3_RST  = 8'b0011_0101;

  // Ramp lengths for the two directions.
  localparam int CwRampLen  = 7;
  localparam int CcwRampLen = 9;

  typedef struct packed {
    logic [5:0]      base_delay;
    logic [7:0]      home_delay;
    logic [3:0][7:0] pattern;
  } cfg_t;

  typedef struct packed {
    logic [1:0] bin_position;
    logic       rejected;
    logic       done_res;
    logic       busy_res;
    logic       step_taken;
    logic [7:0] coil_pattern;
  } result_t;

  // Extra wait added at ramp position k; positions past the ramp add nothing.
  function automatic logic [3:0] ramp_value(input logic ccw, input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = 4'd14;
      4'd1:    r = 4'd13;
      4'd2:    r = 4'd12;
      4'd3:    r = 4'd11;
      4'd4:    r = 4'd9;
      4'd5:    r = 4'd7;
      4'd6:    r = ccw ? 4'd5 : 4'd4;
      4'd7:    r = ccw ? 4'd3 : 4'd0;
      4'd8:    r = ccw ? 4'd1 : 4'd0;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stepper_ramp_sequencer_unit.sv */
// Channel   Direction  Payload
// s_axis    in         tuser: req_type[2:0]; tdata: hall_active[0]
// m_axis    out        tdata: coil_pattern, step_taken, busy_res, done_res,
//                      rejected, bin_position
// cfg       in         cfg_index selects the register, cfg_data is written
//
// Each item passes an input register and a result register; one item per
// cycle is sustained while m_axis is not stalled.
// The state update for an item is one combinational pass of the step core.
// Reset (rst, synchronous) returns all sequencer state to zero and the
// registers to their defaults. A stall on m_axis holds the result and
// lets one more item wait in the input register.
`default_nettype none

module stepper_ramp_sequencer_unit #(
  parameter int QUARTER_STEPS = 50
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] hall_active, [7:1] zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] coil_pattern, [8] step_taken, [9] busy_res, [10] done_res,
  // [11] rejected, [13:12] bin_position, [15:14] zero
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import srs_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       in_valid;
  logic [2:0] in_req;
  logic       in_hall;
  logic       advance;

  srs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // An item moves on when the result register is free or being drained.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= s_axis_tuser;
      in_hall <= s_axis_tdata[0];
    end
  end

  srs_step_core #(
    .QUARTER_STEPS (QUARTER_STEPS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .req_type    (in_req),
    .hall_active (in_hall),
    .cfg         (cfg),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, res.bin_position, res.rejected, res.done_res,
                       res.busy_res, res.step_taken, res.coil_pattern};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srs_cfg_regs.sv */
`default_nettype none

module srs_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  output srs_pkg::cfg_t     cfg
);
  import srs_pkg::*;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_delay <= BASE_DELAY_RST;
      cfg.home_delay <= HOME_DELAY_RST;
      cfg.pattern[0] <= PATTERN_0_RST;
      cfg.pattern[1] <= PATTERN_1_RST;
      cfg.pattern[2] <= PATTERN_2_RST;
      cfg.pattern[3] <= PATTERN_3_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_DELAY: cfg.base_delay <= cfg_data[5:0];
        CFG_HOME_DELAY: cfg.home_delay <= cfg_data;
        CFG_PATTERN_0:  cfg.pattern[0] <= cfg_data;
        CFG_PATTERN_1:  cfg.pattern[1] <= cfg_data;
        CFG_PATTERN_2:  cfg.pattern[2] <= cfg_data;
        CFG_PATTERN_3:  cfg.pattern[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srs_step_core.sv */
`default_nettype none

module srs_step_core #(
  parameter int QUARTER_STEPS = 50
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire logic [2:0]     req_type,
  input  wire logic           hall_active,
  input  wire srs_pkg::cfg_t  cfg,
  output srs_pkg::result_t    res
);
  import srs_pkg::*;

  localparam int StepW = $clog2(2 * QUARTER_STEPS + 1);
  localparam logic [StepW-1:0] QuarterTotal = StepW'(QUARTER_STEPS);
  localparam logic [StepW-1:0] HalfTotal    = StepW'(2 * QUARTER_STEPS);

  // Sequencer state.
  logic [1:0]       phase_index, phase_index_next;
  logic [1:0]       tray_bin, tray_bin_next;
  logic [2:0]       move_mode, move_mode_next;
  logic [StepW-1:0] step_number, step_number_next;
  logic [7:0]       wait_left, wait_left_next;
  logic [7:0]       drive_byte, drive_byte_next;

  // Shared step datapath: selected mode and step index.
  logic             is_cmd;
  logic [2:0]       mode_sel;
  logic [StepW-1:0] idx_sel;
  logic [StepW-1:0] total;
  logic [StepW-1:0] mirror;
  logic [StepW-1:0] ramp_pos;
  logic             ccw;
  logic [3:0]       ramp_add;
  logic [6:0]       move_delay;
  logic [7:0]       move_wait;
  logic [7:0]       home_wait;
  logic [1:0]       fwd_phase;
  logic [1:0]       move_phase;
  logic [7:0]       wait_dec;
  logic             stepped, done, rej;

  assign is_cmd   = (req_type == REQ_CW90) || (req_type == REQ_CW180) ||
                    (req_type == REQ_CCW90) || (req_type == REQ_HOME);
  assign mode_sel = (move_mode == MODE_IDLE) ? req_type : move_mode;
  assign idx_sel  = (move_mode == MODE_IDLE) ? '0 : step_number;
  assign total    = (mode_sel == REQ_CW180) ? HalfTotal : QuarterTotal;
  assign mirror   = total - StepW'(1) - idx_sel;
  assign ramp_pos = (mirror < idx_sel) ? mirror : idx_sel;
  assign ccw      = (mode_sel == REQ_CCW90);
  assign ramp_add = (ramp_pos < StepW'(ccw ? CcwRampLen : CwRampLen)) ?
                    ramp_value(ccw, ramp_pos[3:0]) : 4'd0;

  // Wait lengths; a zero delay counts as one tick.
  assign move_delay = {1'b0, cfg.base_delay} + {3'b000, ramp_add};
  assign move_wait  = (move_delay == 7'd0) ? 8'd1 : {1'b0, move_delay};
  assign home_wait  = (cfg.home_delay == 8'd0) ? 8'd1 : cfg.home_delay;
  assign fwd_phase  = phase_index + 2'd1;
  assign move_phase = ccw ? (phase_index - 2'd1) : fwd_phase;
  assign wait_dec   = (wait_left != 8'd0) ? (wait_left - 8'd1) : 8'd0;

  // Next-state logic for one item.
  always_comb begin
    phase_index_next = phase_index;
    tray_bin_next    = tray_bin;
    move_mode_next   = move_mode;
    step_number_next = step_number;
    wait_left_next   = wait_left;
    drive_byte_next  = drive_byte;
    stepped          = 1'b0;
    done             = 1'b0;
    rej              = 1'b0;
    if (is_cmd) begin
      if (move_mode != MODE_IDLE) begin
        rej = 1'b1;
      end else if (req_type == REQ_HOME) begin
        if (hall_active) begin
          done = 1'b1;
        end else begin
          move_mode_next   = REQ_HOME;
          phase_index_next = fwd_phase;
          drive_byte_next  = cfg.pattern[fwd_phase];
          wait_left_next   = home_wait;
          stepped          = 1'b1;
        end
      end else begin
        move_mode_next   = req_type;
        phase_index_next = move_phase;
        drive_byte_next  = cfg.pattern[move_phase];
        step_number_next = StepW'(1);
        wait_left_next   = move_wait;
        stepped          = 1'b1;
      end
    end else if ((req_type == REQ_TICK) && (move_mode != MODE_IDLE)) begin
      wait_left_next = wait_dec;
      if (wait_dec == 8'd0) begin
        if (move_mode == REQ_HOME) begin
          if (hall_active) begin
            move_mode_next = MODE_IDLE;
            done           = 1'b1;
          end else begin
            phase_index_next = fwd_phase;
            drive_byte_next  = cfg.pattern[fwd_phase];
            wait_left_next   = home_wait;
            stepped          = 1'b1;
          end
        end else if (step_number >= total) begin
          case (move_mode)
            REQ_CW90:  tray_bin_next = tray_bin + 2'd1;
            REQ_CW180: tray_bin_next = tray_bin + 2'd2;
            default:   tray_bin_next = tray_bin - 2'd1;
          endcase
          move_mode_next   = MODE_IDLE;
          step_number_next = '0;
          done             = 1'b1;
        end else begin
          phase_index_next = move_phase;
          drive_byte_next  = cfg.pattern[move_phase];
          step_number_next = step_number + StepW'(1);
          wait_left_next   = move_wait;
          stepped          = 1'b1;
        end
      end
    end
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= '0;
      tray_bin    <= '0;
      move_mode   <= MODE_IDLE;
      step_number <= '0;
      wait_left   <= '0;
      drive_byte  <= '0;
    end else if (fire) begin
      phase_index <= phase_index_next;
      tray_bin    <= tray_bin_next;
      move_mode   <= move_mode_next;
      step_number <= step_number_next;
      wait_left   <= wait_left_next;
      drive_byte  <= drive_byte_next;
    end
  end

  // Result of the item being processed.
  always_comb begin
    res.coil_pattern = drive_byte_next;
    res.step_taken   = stepped;
    res.busy_res     = (move_mode_next != MODE_IDLE);
    res.done_res     = done;
    res.rejected     = rej;
    res.bin_position = tray_bin_next;
  end

`ifndef SYNTHESIS
  // After any step the block always has a wait pending.
  a_wait_after_step: assert property (@(posedge clk) disable iff (rst)
    fire && stepped |=> wait_left != 8'd0)
    else $error("step taken without a pending wait");

  // A move never counts past twice a quarter turn.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_number <= HalfTotal)
    else $error("step counter out of range");

  // A rejected command leaves the motor and tray untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    fire && rej |=> $stable(phase_index) && $stable(tray_bin) && $stable(move_mode))
    else $error("rejected command changed state");

  // Completion and rejection never coincide, and completion takes no step.
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    fire && done |-> !rej && !stepped && (move_mode_next == MODE_IDLE))
    else $error("inconsistent completion flags");
`endif

endmodule

`default_nettype wire
